// ----- src/ffra_pkg.sv -----
`timescale 1ns / 1ps
package ffra_pkg;
    localparam int MAX_RANGES = 16;
    localparam int ALLOC_UNIT = 8;
    localparam int HEAP_ADDR_BITS = 24;
    localparam int AW = HEAP_ADDR_BITS;
    localparam int LW = HEAP_ADDR_BITS + 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int IW = $clog2(MAX_RANGES);
    localparam int UB = $clog2(ALLOC_UNIT);
    localparam logic [LW-1:0] HEAP_SIZE_RESET = LW'(1) << HEAP_ADDR_BITS;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_OUTSIDE = 3'd3;
    localparam logic [2:0] ST_OVERLAP = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    // shift command that every cell receives in the same cycle
    typedef enum logic [1:0] {
        SH_NONE,
        SH_DOWN,
        SH_UP
    } t_shift;

    typedef struct packed {
        t_shift          shift;
        logic [IW-1:0]   pos;
        logic            wr;
        logic [IW-1:0]   wr_idx;
        logic [AW-1:0]   wr_base;
        logic [LW-1:0]   wr_len;
        logic            clr;
        logic [LW-1:0]   clr_len;
    } t_cell_cmd;

    // sizes that round past the field saturate, still above any heap end
    function automatic logic [LW-1:0] round_unit(input logic [LW-1:0] v);
        logic [LW:0] s;
        s = {1'b0, v} + (LW+1)'(ALLOC_UNIT - 1);
        s = (s >> UB) << UB;
        return s[LW] ? {LW{1'b1}} : s[LW-1:0];
    endfunction
endpackage

// ----- src/ffra_cell.sv -----
`timescale 1ns / 1ps
module ffra_cell
    import ffra_pkg::*;
(
    input  logic            i_clk,
    input  logic [IW-1:0]   i_idx,
    input  t_cell_cmd       i_cmd,
    input  logic [AW-1:0]   i_lo_base,
    input  logic [LW-1:0]   i_lo_len,
    input  logic [AW-1:0]   i_hi_base,
    input  logic [LW-1:0]   i_hi_len,
    output logic [AW-1:0]   o_base,
    output logic [LW-1:0]   o_len
);
    logic [AW-1:0] r_base, n_base;
    logic [LW-1:0] r_len, n_len;

    always_comb begin
        n_base = r_base;
        n_len  = r_len;
        if (i_cmd.clr) begin
            n_base = '0;
            n_len  = (i_idx == '0) ? i_cmd.clr_len : '0;
        end else if (i_cmd.wr && i_cmd.wr_idx == i_idx) begin
            n_base = i_cmd.wr_base;
            n_len  = i_cmd.wr_len;
        end else if (i_cmd.shift == SH_DOWN && i_idx >= i_cmd.pos) begin
            n_base = i_hi_base;
            n_len  = i_hi_len;
        end else if (i_cmd.shift == SH_UP && i_idx > i_cmd.pos) begin
            n_base = i_lo_base;
            n_len  = i_lo_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_len  <= n_len;
    end

    assign o_base = r_base;
    assign o_len  = r_len;
endmodule

// ----- src/first_fit_range_allocator.sv -----
`timescale 1ns / 1ps
// result path: a scan that visits one table cell per cycle, a decide step for
// frees and a shift step when the table changes; zero sizes skip the scan
// one item at a time; a new item is taken once the last result is registered,
// and a stalled result holds off only the result of the next item
// synchronous active-low reset rebuilds the table as one range of heap_size capped
// and rounded down to ALLOC_UNIT, ready for input in the cycle after reset ends
module first_fit_range_allocator
    import ffra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [55:0]       s_axis_tdata,  // operation, size, address
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata   // status, granted_address, free_total
);
    typedef enum logic [2:0] {
        S_RESET, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_OUT
    } t_state;

    t_state          r_state;
    logic [LW-1:0]   r_heap_size, r_heap_end, r_free;
    logic [CW-1:0]   r_count;
    logic [1:0]      r_op;
    logic [LW-1:0]   r_len;
    logic [AW-1:0]   r_addr;
    logic [CW-1:0]   r_i;
    logic [2:0]      r_st;
    logic [AW-1:0]   r_grant;
    logic            r_ovalid;
    logic [55:0]     r_odata;
    t_cell_cmd       r_cmd_hold;
    t_cell_cmd       cmd;

    logic [AW-1:0] base [MAX_RANGES];
    logic [LW-1:0] len  [MAX_RANGES];

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++) begin : gen_cell
            ffra_cell u_cell (
                .i_clk     (i_clk),
                .i_idx     (IW'(g)),
                .i_cmd     (cmd),
                .i_lo_base (g == 0 ? base[0] : base[(g == 0) ? 0 : g-1]),
                .i_lo_len  (g == 0 ? len[0]  : len[(g == 0) ? 0 : g-1]),
                .i_hi_base (g == MAX_RANGES-1 ? base[g] :
                            base[(g == MAX_RANGES-1) ? g : g+1]),
                .i_hi_len  (g == MAX_RANGES-1 ? len[g] :
                            len[(g == MAX_RANGES-1) ? g : g+1]),
                .o_base    (base[g]),
                .o_len     (len[g])
            );
        end
    endgenerate

    // scan and decision view of the cell under the index
    logic [IW-1:0] ix, ixm;
    logic [AW-1:0] cur_base, prv_base;
    logic [LW-1:0] cur_len, prv_len;
    logic          in_range, has_prev;
    logic [LW:0]   blk_end, top;
    logic [LW-1:0] init_h;

    assign ix       = r_i[IW-1:0];
    assign ixm      = ix - IW'(1);
    assign cur_base = base[ix];
    assign cur_len  = len[ix];
    assign prv_base = base[ixm];
    assign prv_len  = len[ixm];
    assign in_range = r_i < r_count;
    assign has_prev = r_i != '0;
    assign blk_end  = {1'b0, LW'(r_addr)} + {1'b0, r_len};
    assign top      = has_prev ? ({1'b0, LW'(prv_base)} + {1'b0, prv_len}) : '0;

    always_comb begin
        logic [LW-1:0] h;
        h = r_heap_size;
        if (h > HEAP_SIZE_RESET) h = HEAP_SIZE_RESET;
        init_h = (h >> UB) << UB;
    end

    logic [1:0]    in_op;
    logic [LW-1:0] in_size;
    logic [AW-1:0] in_addr;
    assign in_op   = s_axis_tdata[1:0];
    assign in_size = s_axis_tdata[26:2];
    assign in_addr = s_axis_tdata[50:27];

    assign cmd = (r_state == S_SHIFT) ? r_cmd_hold :
                 ((r_state == S_RESET) ? t_cell_cmd'{shift: SH_NONE, pos: '0, wr: 1'b0,
                   wr_idx: '0, wr_base: '0, wr_len: '0, clr: 1'b1,
                   clr_len: init_h} : '0);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == 1'b0) ? 32'(r_heap_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RESET;
            r_ovalid    <= 1'b0;
            r_heap_size <= HEAP_SIZE_RESET;
            r_cmd_hold  <= '0;
            r_op        <= OP_ALLOC;
        end else begin
            if (psel && penable && pwrite && paddr[2] == 1'b0)
                r_heap_size <= pwdata[LW-1:0];
            if (r_ovalid && m_axis_tready && r_state != S_OUT)
                r_ovalid <= 1'b0;
            case (r_state)
                S_RESET: begin
                    r_heap_end <= init_h;
                    r_free     <= init_h;
                    r_count    <= (init_h == '0) ? '0 : CW'(1);
                    // init jumps through S_RESET and reports from there
                    if (r_op == OP_INIT) begin
                        r_state <= S_OUT;
                        r_op    <= OP_ALLOC;
                        r_st    <= ST_OK;
                        r_grant <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= in_op;
                        r_len   <= round_unit(in_size);
                        r_addr  <= in_addr;
                        r_i     <= '0;
                        r_grant <= '0;
                        r_st    <= ST_OK;
                        if (in_op == OP_INIT) begin
                            r_state <= S_RESET;
                        end else if ((in_op == OP_ALLOC || in_op == OP_FREE)
                                     && in_size == '0) begin
                            r_st    <= ST_ZERO;
                            r_state <= S_OUT;
                        end else if (in_op == OP_ALLOC || in_op == OP_FREE) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_op == OP_ALLOC) begin
                        if (!in_range) begin
                            r_st    <= ST_NOFIT;
                            r_state <= S_OUT;
                        end else if (cur_len >= r_len) begin
                            r_grant <= cur_base;
                            r_free  <= r_free - r_len;
                            if (cur_len == r_len) begin
                                r_cmd_hold <= '{shift: SH_DOWN, pos: ix, wr: 1'b0,
                                    wr_idx: '0, wr_base: '0, wr_len: '0,
                                    clr: 1'b0, clr_len: '0};
                                r_count <= r_count - CW'(1);
                            end else begin
                                r_cmd_hold <= '{shift: SH_NONE, pos: ix, wr: 1'b1,
                                    wr_idx: ix, wr_base: cur_base + AW'(r_len),
                                    wr_len: cur_len - r_len, clr: 1'b0,
                                    clr_len: '0};
                            end
                            r_state <= S_SHIFT;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        if (blk_end > {1'b0, r_heap_end}) begin
                            r_st    <= ST_OUTSIDE;
                            r_state <= S_OUT;
                        end else if (in_range && cur_base < r_addr) begin
                            r_i <= r_i + CW'(1);
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (top > {1'b0, LW'(r_addr)} ||
                        (in_range && blk_end > {1'b0, LW'(cur_base)})) begin
                        r_st    <= ST_OVERLAP;
                        r_state <= S_OUT;
                    end else if (has_prev && top == {1'b0, LW'(r_addr)}) begin
                        if (in_range && blk_end == {1'b0, LW'(cur_base)}) begin
                            r_cmd_hold <= '{shift: SH_DOWN, pos: ix, wr: 1'b1,
                                wr_idx: ixm, wr_base: prv_base,
                                wr_len: prv_len + r_len + cur_len,
                                clr: 1'b0, clr_len: '0};
                            r_count <= r_count - CW'(1);
                        end else begin
                            r_cmd_hold <= '{shift: SH_NONE, pos: ix, wr: 1'b1,
                                wr_idx: ixm, wr_base: prv_base,
                                wr_len: prv_len + r_len, clr: 1'b0, clr_len: '0};
                        end
                        r_free  <= r_free + r_len;
                        r_state <= S_SHIFT;
                    end else if (in_range && blk_end == {1'b0, LW'(cur_base)}) begin
                        r_cmd_hold <= '{shift: SH_NONE, pos: ix, wr: 1'b1,
                            wr_idx: ix, wr_base: r_addr, wr_len: cur_len + r_len,
                            clr: 1'b0, clr_len: '0};
                        r_free  <= r_free + r_len;
                        r_state <= S_SHIFT;
                    end else if (r_count >= CW'(MAX_RANGES)) begin
                        r_st    <= ST_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_cmd_hold <= '{shift: SH_UP, pos: ix, wr: 1'b1,
                            wr_idx: ix, wr_base: r_addr, wr_len: r_len,
                            clr: 1'b0, clr_len: '0};
                        r_count <= r_count + CW'(1);
                        r_free  <= r_free + r_len;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'b0, r_free, r_grant, r_st};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_RESET;
            endcase
        end
    end
endmodule

// ----- src/ffra_checker.sv -----
`timescale 1ns / 1ps
module ffra_checker
    import ffra_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_FULL)
        else $error("bad status");
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[26:3] == '0)
        else $error("address on failure");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
